[hw/rtl/lfr_pkg.sv]
package lfr_pkg;

    // Field widths fixed by the frame format
    localparam int unsigned ByteW    = 8;
    localparam int unsigned StampW   = 32;
    localparam int unsigned GapW     = 16;
    localparam int unsigned PosW     = 4;
    localparam int unsigned EventW   = 3;
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 32;

    // Special byte values on the bus
    localparam logic [ByteW-1:0] BreakByte = 8'h00;
    localparam logic [ByteW-1:0] SyncByte  = 8'h55;

    // Gap limit after reset, in milliseconds
    localparam logic [GapW-1:0] GapResetMs = 16'd100;

    // Frame phase, one-hot
    typedef enum logic [3:0] {
        PH_BREAK = 4'b0001,
        PH_SYNC  = 4'b0010,
        PH_IDENT = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    // Event reported for every received byte
    typedef enum logic [EventW-1:0] {
        EV_IGNORED   = 3'd0,
        EV_BREAK     = 3'd1,
        EV_SYNC_OK   = 3'd2,
        EV_SYNC_ERR  = 3'd3,
        EV_IDENT     = 3'd4,
        EV_DATA      = 3'd5,
        EV_FRAME_OK  = 3'd6,
        EV_CSUM_FAIL = 3'd7
    } event_t;

    // One result item
    typedef struct packed {
        event_t            event_code;
        logic              timed_out;
        logic [ByteW-1:0]  frame_ident;
        logic [PosW-1:0]   byte_position;
        logic [ByteW-1:0]  checksum_received;
        logic [ByteW-1:0]  checksum_computed;
    } result_t;

    // 8-bit add with end-around carry
    function automatic logic [ByteW-1:0] carry_add(input logic [ByteW-1:0] a,
                                                   input logic [ByteW-1:0] b);
        logic [ByteW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ByteW-1:0] + {{(ByteW-1){1'b0}}, s[ByteW]};
    endfunction

endpackage

[hw/rtl/lfr_frame_fsm.sv]
module lfr_frame_fsm
    import lfr_pkg::*;
#(
    parameter int unsigned DATA_BYTES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [ByteW-1:0]  rx_byte,
    input  logic [StampW-1:0] arrival_ms,
    input  logic [GapW-1:0]   gap_timeout_ms,
    output result_t           result
);

    localparam logic [PosW-1:0] DataCount = PosW'(DATA_BYTES);

    phase_t             phase_reg,   phase_next;
    logic [ByteW-1:0]   ident_reg,   ident_next;
    logic [PosW-1:0]    count_reg,   count_next;
    logic [ByteW-1:0]   sum_reg,     sum_next;
    logic [StampW-1:0]  last_reg;

    logic [StampW-1:0]  gap;
    logic               timeout;
    phase_t             phase_eff;
    logic [PosW-1:0]    count_eff;
    logic [PosW-1:0]    count_inc;
    logic [PosW-1:0]    pos;
    event_t             ev;
    logic [ByteW-1:0]   c_rx;
    logic [ByteW-1:0]   c_calc;

    // Gap check against the previous byte, modulo 2^32
    assign gap       = arrival_ms - last_reg;
    assign timeout   = (phase_reg != PH_BREAK) && (gap > {{(StampW-GapW){1'b0}}, gap_timeout_ms});
    assign phase_eff = timeout ? PH_BREAK : phase_reg;
    assign count_eff = timeout ? '0 : count_reg;
    assign count_inc = count_eff + PosW'(1);

    // Frame tracking for the current byte
    always_comb
    begin
        phase_next = phase_eff;
        count_next = count_eff;
        ident_next = ident_reg;
        sum_next   = sum_reg;
        ev         = EV_IGNORED;
        c_rx       = '0;
        c_calc     = '0;
        pos        = count_eff;
        case (phase_eff)
            PH_BREAK:
            begin
                if (rx_byte == BreakByte)
                begin
                    ev         = EV_BREAK;
                    phase_next = PH_SYNC;
                end
            end
            PH_SYNC:
            begin
                if (rx_byte == SyncByte)
                begin
                    ev         = EV_SYNC_OK;
                    phase_next = PH_IDENT;
                end
                else
                begin
                    ev         = EV_SYNC_ERR;
                    phase_next = PH_BREAK;
                end
            end
            PH_IDENT:
            begin
                ident_next = rx_byte;
                sum_next   = rx_byte;
                count_next = '0;
                pos        = '0;
                ev         = EV_IDENT;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                pos = count_inc;
                if (count_inc <= DataCount)
                begin
                    sum_next   = carry_add(sum_reg, rx_byte);
                    count_next = count_inc;
                    ev         = EV_DATA;
                end
                else
                begin
                    // Checksum byte closes the frame
                    c_rx       = rx_byte;
                    c_calc     = ~sum_reg;
                    ev         = (rx_byte == ~sum_reg) ? EV_FRAME_OK : EV_CSUM_FAIL;
                    phase_next = PH_BREAK;
                    count_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_BREAK;
                count_next = '0;
            end
        endcase
    end

    // Frame state, updated once per handled byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BREAK;
            ident_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            last_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            ident_reg <= ident_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            last_reg  <= arrival_ms;
        end
    end

    assign result.event_code        = ev;
    assign result.timed_out         = timeout;
    assign result.frame_ident       = ident_next;
    assign result.byte_position     = pos;
    assign result.checksum_received = c_rx;
    assign result.checksum_computed = c_calc;

endmodule

[hw/rtl/lfr_out_stage.sv]
module lfr_out_stage
    import lfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  result_t              result,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] timed_out, [8:1] frame_ident, [12:9] byte_position,
    // [20:13] checksum_received, [28:21] checksum_computed, [31:29] zero
    output logic [OutDataW-1:0]  m_tdata,
    // [2:0] event_code
    output logic [EventW-1:0]    m_tuser
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Result is held until the downstream transfer completes
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.event_code;
    assign m_tdata  = {3'b000,
                       data_reg.checksum_computed,
                       data_reg.checksum_received,
                       data_reg.byte_position,
                       data_reg.frame_ident,
                       data_reg.timed_out};

endmodule

[hw/rtl/lin_frame_receiver.sv]
// Channel   Direction  Payload
// s_*       in         s_tdata [7:0] rx_byte, [39:8] arrival_ms
// m_*       out        m_tdata flags, identifier, position, checksums; m_tuser event code
// cfg_*     in         cfg_data [15:0] gap_timeout_ms
//
// A byte is held in the input register and is handled on the way into
// the result register, from which its result is offered downstream.
// One byte per cycle is sustained while the output is not stalled;
// the frame state register is the only loop.
// A stalled output holds the result register and the input register backs up.
// Reset returns to the break wait with a gap limit of 100 ms.
module lin_frame_receiver
    import lfr_pkg::*;
#(
    parameter int unsigned DATA_BYTES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] rx_byte, [39:8] arrival_ms
    input  logic [InDataW-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] timed_out, [8:1] frame_ident, [12:9] byte_position,
    // [20:13] checksum_received, [28:21] checksum_computed, [31:29] zero
    output logic [OutDataW-1:0]  m_tdata,
    // [2:0] event_code
    output logic [EventW-1:0]    m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [GapW-1:0]      cfg_data
);

    logic               in_valid_reg;
    logic [ByteW-1:0]   in_byte_reg;
    logic [StampW-1:0]  in_stamp_reg;
    logic [GapW-1:0]    gap_limit_reg;
    logic               step_en;
    logic               s_xfer;
    result_t            result;

    // Handle a byte when the result register is free or being drained
    assign step_en  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign s_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Gap limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_limit_reg <= GapResetMs;
        else if (cfg_valid)
            gap_limit_reg <= cfg_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_byte_reg  <= s_tdata[ByteW-1:0];
            in_stamp_reg <= s_tdata[ByteW +: StampW];
        end
    end

    lfr_frame_fsm #(
        .DATA_BYTES (DATA_BYTES)
    ) u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .rx_byte        (in_byte_reg),
        .arrival_ms     (in_stamp_reg),
        .gap_timeout_ms (gap_limit_reg),
        .result         (result)
    );

    lfr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step_en),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
